// ===== src/lrf_pkg.sv =====
// lrf_pkg: shared types, constants and microprogram for the regression fit core
// no dependencies; imported by lrf_ctrl, lrf_dp, linear_regression_fit_core and the testbench
package lrf_pkg;

    // default parameter values
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_MAX_SAMPLES   = 4096;
    localparam int DEF_FRACTION_BITS = 16;

    // fixed result widths
    localparam int FIT_W      = 48;
    localparam int CORR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CORR_SHIFT = 62;

    // microprogram size
    localparam int NUM_STEPS = 15;
    localparam int STEP_W    = 4;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} t_state;
    typedef enum logic [1:0] {OP_NONE, OP_MUL, OP_DIV, OP_SQRT} t_op;
    typedef enum logic [3:0] {
        SRC_N, SRC_SX, SRC_SY, SRC_SX2, SRC_SY2, SRC_SXY, SRC_VXX, SRC_VYY, SRC_VXY
    } t_src;
    typedef enum logic [2:0] {DST_VXX, DST_VYY, DST_VXY, DST_TN, DST_TD} t_dst;
    typedef enum logic [1:0] {DIV_SLOPE, DIV_ICPT, DIV_CORR} t_div;
    typedef enum logic [1:0] {CHK_NONE, CHK_X, CHK_Y} t_chk;
    typedef enum logic [1:0] {FS_OK, FS_XVAR, FS_YVAR, FS_COUNT} t_fit_status;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        logic neg;
        logic clr;
        t_dst dst;
        t_div dkind;
        t_chk chk;
        logic fin;
    } t_uop;

    typedef struct packed {
        logic go;
        logic finish;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic ovf;
        logic vxx_zero;
        logic vyy_zero;
    } t_dp_stat;

    function automatic t_uop mk(input t_op op, input t_src a, input t_src b,
                                input logic neg, input logic clr, input t_dst dst,
                                input t_div dk, input t_chk chk, input logic fin);
        t_uop u;
        begin
            u.op = op; u.a = a; u.b = b; u.neg = neg; u.clr = clr;
            u.dst = dst; u.dkind = dk; u.chk = chk; u.fin = fin;
            return u;
        end
    endfunction

    // variance terms, slope, intercept, then correlation
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        begin
            case (step)
                4'd0:  u = mk(OP_MUL, SRC_N, SRC_SX2, 1'b0, 1'b1, DST_VXX, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd1:  u = mk(OP_MUL, SRC_SX, SRC_SX, 1'b1, 1'b0, DST_VXX, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd2:  u = mk(OP_MUL, SRC_N, SRC_SY2, 1'b0, 1'b1, DST_VYY, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd3:  u = mk(OP_MUL, SRC_SY, SRC_SY, 1'b1, 1'b0, DST_VYY, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd4:  u = mk(OP_MUL, SRC_N, SRC_SXY, 1'b0, 1'b1, DST_VXY, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd5:  u = mk(OP_MUL, SRC_SX, SRC_SY, 1'b1, 1'b0, DST_VXY, DIV_SLOPE,
                              CHK_X, 1'b0);
                4'd6:  u = mk(OP_DIV, SRC_N, SRC_N, 1'b0, 1'b0, DST_TN, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd7:  u = mk(OP_MUL, SRC_SY, SRC_VXX, 1'b0, 1'b1, DST_TN, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd8:  u = mk(OP_MUL, SRC_VXY, SRC_SX, 1'b1, 1'b0, DST_TN, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd9:  u = mk(OP_MUL, SRC_N, SRC_VXX, 1'b0, 1'b1, DST_TD, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd10: u = mk(OP_DIV, SRC_N, SRC_N, 1'b0, 1'b0, DST_TN, DIV_ICPT,
                              CHK_Y, 1'b0);
                4'd11: u = mk(OP_MUL, SRC_VXY, SRC_VXY, 1'b0, 1'b1, DST_TN, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd12: u = mk(OP_MUL, SRC_VXX, SRC_VYY, 1'b0, 1'b1, DST_TD, DIV_SLOPE,
                              CHK_NONE, 1'b0);
                4'd13: u = mk(OP_DIV, SRC_N, SRC_N, 1'b0, 1'b0, DST_TN, DIV_CORR,
                              CHK_NONE, 1'b0);
                4'd14: u = mk(OP_SQRT, SRC_N, SRC_N, 1'b0, 1'b0, DST_TN, DIV_CORR,
                              CHK_NONE, 1'b1);
                default: u = mk(OP_NONE, SRC_N, SRC_N, 1'b0, 1'b0, DST_TN, DIV_SLOPE,
                                CHK_NONE, 1'b1);
            endcase
            return u;
        end
    endfunction

endpackage

// ===== src/lrf_ctrl.sv =====
// lrf_ctrl: sequencer that steps the datapath through the fit microprogram
// depends on lrf_pkg
module lrf_ctrl import lrf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_last,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    t_uop                w_uop;

    assign w_uop = ucode(r_step);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_accept && i_last) begin
                    n_state = ST_ISSUE;
                    n_step  = '0;
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_stat.done) begin
                    if (w_uop.fin
                        || (w_uop.chk == CHK_X && (i_stat.ovf || i_stat.vxx_zero))
                        || (w_uop.chk == CHK_Y && i_stat.vyy_zero)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ISSUE;
                        n_step  = r_step + 1'b1;
                    end
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.go     = (r_state == ST_ISSUE);
        o_cmd.finish = (r_state == ST_DONE);
        o_cmd.uop    = w_uop;
        o_busy       = (r_state != ST_IDLE);
        o_valid      = (r_state == ST_DONE);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTH
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> o_busy)
        else $error("last word did not start the fit");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < STEP_W'(NUM_STEPS))
        else $error("microprogram step out of range");
    a_go_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.go |=> !i_stat.done || w_uop.op == OP_MUL)
        else $error("divide or root finished straight after issue");
`endif

endmodule

// ===== src/lrf_dp.sv =====
// lrf_dp: running sums plus shared shift-add multiplier, restoring divider and root unit
// depends on lrf_pkg; driven by lrf_ctrl commands
module lrf_dp import lrf_pkg::*; #(
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_last,
    input  logic [SAMPLE_BITS-1:0] i_x_value,
    input  logic [SAMPLE_BITS-1:0] i_y_value,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic [FIT_W-1:0]       o_slope,
    output logic [FIT_W-1:0]       o_intercept,
    output logic [CORR_W-1:0]      o_correlation,
    output logic [STATUS_W-1:0]    o_fit_status
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int PR_W  = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int P_W   = 2 * CNT_W + 2 * SAMPLE_BITS;
    localparam int BW    = 2 * P_W + 64;
    localparam int HW    = BW / 2;
    localparam int IT_W  = $clog2(BW + 1);
    localparam logic [FIT_W-1:0] CAP_POS = {1'b0, {(FIT_W-1){1'b1}}};
    localparam logic [FIT_W-1:0] CAP_NEG = {1'b1, {(FIT_W-1){1'b0}}};

    // running sums
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_ovf;
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic [SQ_W-1:0]         r_sx2, r_sy2;
    logic signed [PR_W-1:0]  r_sxy;

    logic signed [SAMPLE_BITS-1:0]   w_x, w_y;
    logic signed [2*SAMPLE_BITS-1:0] w_xx, w_yy, w_xy;

    assign w_x  = i_x_value;
    assign w_y  = i_y_value;
    assign w_xx = w_x * w_x;
    assign w_yy = w_y * w_y;
    assign w_xy = w_x * w_y;

    // accumulate one word per cycle while words are accepted, clear after the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sx2 <= '0;
            r_sy2 <= '0;
            r_sxy <= '0;
        end else if (i_accept) begin
            if (r_cnt == CNT_W'(MAX_SAMPLES)) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sx  <= r_sx + {{(SUM_W-SAMPLE_BITS){w_x[SAMPLE_BITS-1]}}, w_x};
                r_sy  <= r_sy + {{(SUM_W-SAMPLE_BITS){w_y[SAMPLE_BITS-1]}}, w_y};
                r_sx2 <= r_sx2 + {{(SQ_W-2*SAMPLE_BITS+1){1'b0}}, w_xx[2*SAMPLE_BITS-2:0]};
                r_sy2 <= r_sy2 + {{(SQ_W-2*SAMPLE_BITS+1){1'b0}}, w_yy[2*SAMPLE_BITS-2:0]};
                r_sxy <= r_sxy + {{(PR_W-2*SAMPLE_BITS){w_xy[2*SAMPLE_BITS-1]}}, w_xy};
            end
        end
    end

    // working registers
    logic [BW-1:0] r_vxx, r_vyy, r_vxy, r_tn, r_td, r_tq;
    logic [FIT_W-1:0]  r_slope, r_icpt;
    logic [CORR_W-1:0] r_corr;

    // engine registers
    t_op            r_op;
    logic [IT_W-1:0] r_it;
    t_dst           r_dst;
    t_div           r_dk;
    logic           r_dneg;
    logic [BW-1:0]  r_ma, r_mb, r_acc;
    logic [BW-1:0]  r_dn, r_dd, r_q;
    logic [BW:0]    r_rem;
    logic [BW-1:0]  r_sr;
    logic [HW-1:0]  r_rt;
    logic [HW+1:0]  r_srem;

    // operand selection for the multiplier
    logic [BW-1:0] w_a, w_b;
    always_comb begin
        case (i_cmd.uop.a)
            SRC_N:   w_a = {{(BW-CNT_W){1'b0}}, r_cnt};
            SRC_SX:  w_a = {{(BW-SUM_W){r_sx[SUM_W-1]}}, r_sx};
            SRC_SY:  w_a = {{(BW-SUM_W){r_sy[SUM_W-1]}}, r_sy};
            SRC_SX2: w_a = {{(BW-SQ_W){1'b0}}, r_sx2};
            SRC_SY2: w_a = {{(BW-SQ_W){1'b0}}, r_sy2};
            SRC_SXY: w_a = {{(BW-PR_W){r_sxy[PR_W-1]}}, r_sxy};
            SRC_VXX: w_a = r_vxx;
            SRC_VYY: w_a = r_vyy;
            SRC_VXY: w_a = r_vxy;
            default: w_a = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.uop.b)
            SRC_N:   w_b = {{(BW-CNT_W){1'b0}}, r_cnt};
            SRC_SX:  w_b = {{(BW-SUM_W){r_sx[SUM_W-1]}}, r_sx};
            SRC_SY:  w_b = {{(BW-SUM_W){r_sy[SUM_W-1]}}, r_sy};
            SRC_SX2: w_b = {{(BW-SQ_W){1'b0}}, r_sx2};
            SRC_SY2: w_b = {{(BW-SQ_W){1'b0}}, r_sy2};
            SRC_SXY: w_b = {{(BW-PR_W){r_sxy[PR_W-1]}}, r_sxy};
            SRC_VXX: w_b = r_vxx;
            SRC_VYY: w_b = r_vyy;
            SRC_VXY: w_b = r_vxy;
            default: w_b = '0;
        endcase
    end

    // divider load values: rounded fixed-point quotient or correlation ratio
    logic [BW-1:0] w_dnum, w_dden, w_dabs, w_dn0, w_dd0;
    logic          w_dneg;
    always_comb begin
        if (i_cmd.uop.dkind == DIV_SLOPE) begin
            w_dnum = r_vxy;
            w_dden = r_vxx;
        end else begin
            w_dnum = r_tn;
            w_dden = r_td;
        end
        w_dneg = w_dnum[BW-1];
        w_dabs = w_dneg ? (~w_dnum + 1'b1) : w_dnum;
        if (i_cmd.uop.dkind == DIV_CORR) begin
            w_dn0 = w_dnum << CORR_SHIFT;
            w_dd0 = w_dden;
        end else begin
            w_dn0 = (w_dabs << (FRACTION_BITS + 1)) + w_dden;
            w_dd0 = w_dden << 1;
        end
    end

    // one restoring divide step
    logic [BW:0] w_rsh, w_rnx;
    logic        w_dge;
    assign w_rsh = {r_rem[BW-1:0], r_dn[BW-1]};
    assign w_dge = (w_rsh >= {1'b0, r_dd});
    assign w_rnx = w_dge ? (w_rsh - {1'b0, r_dd}) : w_rsh;

    // one root digit step
    logic [HW+1:0] w_s2, w_trial, w_snx;
    logic          w_sge;
    assign w_s2    = {r_srem[HW-1:0], r_sr[BW-1:BW-2]};
    assign w_trial = {r_rt, 2'b01};
    assign w_sge   = (w_s2 >= w_trial);
    assign w_snx   = w_sge ? (w_s2 - w_trial) : w_s2;

    // saturate the quotient to the fit width and apply sign
    logic [FIT_W-1:0] w_cap, w_mag, w_fit;
    logic             w_over;
    always_comb begin
        w_cap  = r_dneg ? CAP_NEG : CAP_POS;
        w_over = (|r_q[BW-1:FIT_W]) || (r_q[FIT_W-1:0] > w_cap);
        w_mag  = w_over ? w_cap : r_q[FIT_W-1:0];
        w_fit  = r_dneg ? (~w_mag + 1'b1) : w_mag;
    end

    // round half up of the root and sign of the covariance
    logic [CORR_W:0]   w_cinc;
    logic [CORR_W-1:0] w_cmag, w_corr;
    assign w_cinc = {1'b0, r_rt[CORR_W-1:0]} + 1'b1;
    assign w_cmag = w_cinc[CORR_W:1];
    assign w_corr = r_vxy[BW-1] ? (~w_cmag + 1'b1) : w_cmag;

    logic w_done;
    assign w_done = (r_op == OP_MUL && r_mb == '0)
                 || ((r_op == OP_DIV || r_op == OP_SQRT) && r_it == '0);

    // engine control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_NONE;
            r_it <= '0;
        end else if (i_cmd.go) begin
            r_op <= i_cmd.uop.op;
            case (i_cmd.uop.op)
                OP_DIV:  r_it <= IT_W'(BW);
                OP_SQRT: r_it <= IT_W'(HW);
                default: r_it <= '0;
            endcase
        end else if (w_done) begin
            r_op <= OP_NONE;
        end else if (r_op == OP_DIV || r_op == OP_SQRT) begin
            r_it <= r_it - 1'b1;
        end
    end

    // engine datapath and result registers
    always_ff @(posedge i_clk) begin
        if (i_accept && i_last) begin
            r_slope <= '0;
            r_icpt  <= '0;
            r_corr  <= '0;
        end
        if (i_cmd.go) begin
            r_dst <= i_cmd.uop.dst;
            r_dk  <= i_cmd.uop.dkind;
            case (i_cmd.uop.op)
                OP_MUL: begin
                    r_ma <= i_cmd.uop.neg ? (~w_a + 1'b1) : w_a;
                    r_mb <= w_b;
                    if (i_cmd.uop.clr) begin
                        r_acc <= '0;
                    end
                end
                OP_DIV: begin
                    r_dn   <= w_dn0;
                    r_dd   <= w_dd0;
                    r_dneg <= w_dneg;
                    r_rem  <= '0;
                    r_q    <= '0;
                end
                OP_SQRT: begin
                    r_sr   <= r_tq;
                    r_rt   <= '0;
                    r_srem <= '0;
                end
                default: ;
            endcase
        end else if (w_done) begin
            case (r_op)
                OP_MUL: begin
                    case (r_dst)
                        DST_VXX: r_vxx <= r_acc;
                        DST_VYY: r_vyy <= r_acc;
                        DST_VXY: r_vxy <= r_acc;
                        DST_TN:  r_tn  <= r_acc;
                        DST_TD:  r_td  <= r_acc;
                        default: ;
                    endcase
                end
                OP_DIV: begin
                    case (r_dk)
                        DIV_SLOPE: r_slope <= w_fit;
                        DIV_ICPT:  r_icpt  <= w_fit;
                        default:   r_tq    <= r_q;
                    endcase
                end
                OP_SQRT: r_corr <= w_corr;
                default: ;
            endcase
        end else begin
            case (r_op)
                OP_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
                OP_DIV: begin
                    r_rem <= w_rnx;
                    r_dn  <= r_dn << 1;
                    r_q   <= {r_q[BW-2:0], w_dge};
                end
                OP_SQRT: begin
                    r_srem <= w_snx;
                    r_sr   <= r_sr << 2;
                    r_rt   <= {r_rt[HW-2:0], w_sge};
                end
                default: ;
            endcase
        end
    end

    // status
    always_comb begin
        o_stat.done     = w_done;
        o_stat.ovf      = r_ovf;
        o_stat.vxx_zero = (r_vxx == '0);
        o_stat.vyy_zero = (r_vyy == '0);
        if (r_ovf) begin
            o_fit_status = FS_COUNT;
        end else if (r_vxx == '0) begin
            o_fit_status = FS_XVAR;
        end else if (r_vyy == '0) begin
            o_fit_status = FS_YVAR;
        end else begin
            o_fit_status = FS_OK;
        end
    end

    assign o_slope       = r_slope;
    assign o_intercept   = r_icpt;
    assign o_correlation = r_corr;

endmodule

// ===== src/linear_regression_fit_core.sv =====
// Throughput: one (x, y) word per cycle while a set accumulates.
// After the last word the fit runs on the shared multiplier and divider, one bit per cycle;
//   BW = 4*clog2(MAX_SAMPLES+1) + 4*SAMPLE_BITS + 64 is their width, and no new word is
//   taken until the core returns to idle after the result strobe.
// Reset: synchronous active-low i_rst_n clears all sums and returns to idle.
// The result strobe lasts one cycle; the receiver cannot stall.
module linear_regression_fit_core import lrf_pkg::*; #(
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [SAMPLE_BITS-1:0] i_x_value,
    input  logic [SAMPLE_BITS-1:0] i_y_value,
    input  logic                   i_last_sample,
    output logic                   o_valid,
    output logic [FIT_W-1:0]       o_slope,
    output logic [FIT_W-1:0]       o_intercept,
    output logic [CORR_W-1:0]      o_correlation,
    output logic [STATUS_W-1:0]    o_fit_status
);

    logic     w_accept;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // word taken when idle
    assign w_accept = i_start && !o_busy;

    lrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_last  (i_last_sample),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    lrf_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_SAMPLES  (MAX_SAMPLES),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_last       (i_last_sample),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_slope      (o_slope),
        .o_intercept  (o_intercept),
        .o_correlation(o_correlation),
        .o_fit_status (o_fit_status)
    );

endmodule

// ===== bench/testbench.sv =====
// testbench for linear_regression_fit_core: directed sets then random sets, with
// results checked against a wide-integer model of the fit; depends on lrf_pkg
`timescale 1ns / 100ps

module testbench;
    import lrf_pkg::*;

    localparam int SB  = DEF_SAMPLE_BITS;
    localparam int FB  = DEF_FRACTION_BITS;
    localparam int MAXN = DEF_MAX_SAMPLES;

    typedef logic [255:0] t_wide;

    typedef struct {
        logic [FIT_W-1:0]    slope;
        logic [FIT_W-1:0]    icpt;
        logic [CORR_W-1:0]   corr;
        t_fit_status         status;
    } t_fit;

    typedef struct {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic                 last;
        logic                 typed;
        t_fit                 fit;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [SB-1:0]        i_x_value;
    logic [SB-1:0]        i_y_value;
    logic                 i_last_sample;
    logic                 o_valid;
    logic [FIT_W-1:0]     o_slope;
    logic [FIT_W-1:0]     o_intercept;
    logic [CORR_W-1:0]    o_correlation;
    logic [STATUS_W-1:0]  o_fit_status;

    int    errors = 0;
    t_fit  fits_due[$];

    // model count and overflow flag; sums kept at 256 bits two's complement
    int    n_acc;
    logic  count_ovf;
    t_wide sum_x, sum_y, sum_xx, sum_yy, sum_xy;

    linear_regression_fit_core uut (.*);

    // clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    task automatic report(input string what, input t_wide got, input t_wide want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_wide sext(input logic [SB-1:0] v);
        return {{(256-SB){v[SB-1]}}, v};
    endfunction

    function automatic t_wide int_sqrt(input t_wide v);
        t_wide r, c;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            c = r | (t_wide'(1) << i);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    // num * 2^FB / den rounded half away from zero, saturated to 48 bits
    function automatic logic [FIT_W-1:0] scaled_quot(input t_wide num, input t_wide den);
        logic  neg;
        t_wide m, q, cap;
        neg = num[255];
        m   = (neg ? -num : num) << FB;
        q   = ((m << 1) + den) / (den << 1);
        cap = neg ? (t_wide'(1) << 47) : ((t_wide'(1) << 47) - 1);
        if (q > cap) q = cap;
        return neg ? -q[FIT_W-1:0] : q[FIT_W-1:0];
    endfunction

    function automatic void clear_sums();
        n_acc = 0; count_ovf = 1'b0;
        sum_x = '0; sum_y = '0; sum_xx = '0; sum_yy = '0; sum_xy = '0;
    endfunction

    // add one accepted pair; returns 1 with the fit when it closes a set
    function automatic bit add_pair(input logic [SB-1:0] xv, input logic [SB-1:0] yv,
                                    input logic last, output t_fit f);
        t_wide x, y, n, vxx, vyy, vxy, a, c;
        x = sext(xv);
        y = sext(yv);
        f = '{slope: '0, icpt: '0, corr: '0, status: FS_OK};
        if (n_acc >= MAXN) begin
            count_ovf = 1'b1;
        end else begin
            n_acc++;
            sum_x += x; sum_y += y;
            sum_xx += x * x; sum_yy += y * y; sum_xy += x * y;
        end
        if (!last) return 0;
        n   = t_wide'(n_acc);
        vxx = n * sum_xx - sum_x * sum_x;
        vyy = n * sum_yy - sum_y * sum_y;
        vxy = n * sum_xy - sum_x * sum_y;
        if (count_ovf) begin
            f.status = FS_COUNT;
        end else if (vxx == 0) begin
            f.status = FS_XVAR;
        end else begin
            f.slope = scaled_quot(vxy, vxx);
            f.icpt  = scaled_quot(sum_y * vxx - vxy * sum_x, n * vxx);
            if (vyy == 0) begin
                f.status = FS_YVAR;
            end else begin
                a = vxy[255] ? -vxy : vxy;
                c = int_sqrt(((a * a) << CORR_SHIFT) / (vxx * vyy));
                c = (c + 1) >> 1;
                f.corr = vxy[255] ? -c[CORR_W-1:0] : c[CORR_W-1:0];
            end
        end
        clear_sums();
        return 1;
    endfunction

    // send one word, holding start until accepted
    task automatic send(input logic [SB-1:0] xv, input logic [SB-1:0] yv,
                        input logic last, input bit typed, input t_fit want);
        int   gap;
        t_fit f;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_x_value     <= xv;
        i_y_value     <= yv;
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (add_pair(xv, yv, last, f)) fits_due.push_back(typed ? want : f);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_fit w;
        if (i_rst_n && o_valid) begin
            if (fits_due.size() == 0) begin
                report("unexpected result", t_wide'(o_slope), '0);
            end else begin
                w = fits_due.pop_front();
                if (o_slope !== w.slope) report("slope", o_slope, w.slope);
                if (o_intercept !== w.icpt) report("intercept", o_intercept, w.icpt);
                if (o_correlation !== w.corr) report("correlation", o_correlation, w.corr);
                if (o_fit_status !== w.status) report("status", o_fit_status, w.status);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("FAIL linear_regression_fit_core");
        $finish;
    end

    initial begin
        t_row dir[$];
        t_fit none;
        int   items, len, kind, k;
        logic signed [SB-1:0] cx, cy, xv, yv;
        bit   paused;

        none = '{slope: '0, icpt: '0, corr: '0, status: FS_OK};
        // directed sets: typed rows are the ones readable by eye
        dir = '{
            '{100, -7, 1, 1, '{'0, '0, '0, FS_XVAR}},
            '{3, 4, 0, 0, none},
            '{3, 9, 1, 1, '{'0, '0, '0, FS_XVAR}},
            '{0, 5, 0, 0, none},
            '{1, 5, 1, 1, '{'0, 48'd327680, '0, FS_YVAR}},
            '{0, 0, 0, 0, none},
            '{1, 1, 1, 1, '{48'd65536, '0, 32'd1073741824, FS_OK}},
            '{-32768, 32767, 0, 0, none},
            '{32767, -32768, 1, 1, '{-48'sd65536, -48'sd65536, -32'sd1073741824, FS_OK}},
            '{32767, 32767, 0, 0, none},
            '{-32768, -32768, 0, 0, none},
            '{-1, 0, 0, 0, none},
            '{0, -1, 1, 0, none},
            '{-32768, -32768, 0, 0, none},
            '{-32768, 32767, 0, 0, none},
            '{32767, 0, 1, 0, none},
            '{5, -3, 0, 0, none},
            '{7, 11, 0, 0, none},
            '{-2, 4, 0, 0, none},
            '{1, 1, 0, 0, none},
            '{9, -8, 1, 0, none}
        };

        clear_sums();
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_x_value     <= '0;
        i_y_value     <= '0;
        i_last_sample <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i])
            send(dir[i].x, dir[i].y, dir[i].last, dir[i].typed, dir[i].fit);

        // random sets
        items  = 0;
        paused = 0;
        for (int s = 0; items < 1100 || !paused; s++) begin
            k = $urandom_range(0, 19);
            if (k == 0) len = 1;
            else if (k == 1) len = $urandom_range(17, 200);
            else len = $urandom_range(2, 16);
            kind = $urandom_range(0, 9);
            cx = SB'($urandom); cy = SB'($urandom);
            k  = $urandom_range(0, 7) - 3;
            for (int j = 0; j < len; j++) begin
                xv = SB'($urandom); yv = SB'($urandom);
                case (kind)
                    0: xv = cx;
                    1: yv = cy;
                    2, 3: begin
                        xv = SB'($urandom_range(0, 4000) - 2000);
                        yv = SB'(int'(xv) * k + int'(cy) / 4
                                 + int'($urandom_range(0, 6)) - 3);
                    end
                    default: ;
                endcase
                send(xv, yv, j == len - 1, 0, none);
            end
            items += len;
            // drain the pipeline once between sets
            if (!paused && s >= 10 && $urandom_range(0, 3) == 0) begin
                i_start <= 1'b0;
                wait (fits_due.size() == 0);
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                paused = 1;
            end
        end
        i_start <= 1'b0;

        wait (fits_due.size() == 0);
        repeat (3000) @(posedge i_clk);
        if (errors == 0 && fits_due.size() == 0) begin
            $display("PASS linear_regression_fit_core");
        end else begin
            $display("FAIL linear_regression_fit_core");
        end
        $finish;
    end

endmodule
